// ----- design/fbfl_pkg.sv -----
package fbfl_pkg;

  localparam int unsigned IDX_W          = 8;
  localparam int unsigned MAX_BLOCKS_DEF = 255;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  // command handed from the input channel to the sequencer
  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [IDX_W-1:0] ret_index;
  } cmd_t;

  // finished result handed to the output register
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] granted_index;
    status_e          status;
    logic [IDX_W-1:0] free_count;
  } res_t;

endpackage

// ----- design/fbfl_ram.sv -----
module fbfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 255,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fbfl_seq.sv -----
module fbfl_seq #(
  parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fbfl_pkg::IDX_W-1:0]  block_count_i,
  input  fbfl_pkg::cmd_t              cmd_i,
  output logic                        cmd_ready_o,
  output fbfl_pkg::res_t              res_o,
  input  logic                        res_ready_i
);
  import fbfl_pkg::*;

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [IDX_W-1:0] MaxBlk = IDX_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;     // init walk position
  logic [IDX_W-1:0] n_q;       // pool size being built by init
  logic [IDX_W-1:0] pool_q;
  logic [IDX_W-1:0] head_q;
  logic [IDX_W-1:0] free_q;
  logic [IDX_W-1:0] grant_q;
  status_e          status_q;

  // shared 8-bit adder: init walk step, pop decrement, push increment
  logic [IDX_W-1:0] add_a, add_b, sum;
  always_comb begin
    case (state_q)
      S_INIT: begin
        add_a = cnt_q;
        add_b = IDX_W'(1);
      end
      S_POP: begin
        add_a = free_q;
        add_b = '1;
      end
      default: begin
        add_a = free_q;
        add_b = IDX_W'(1);
      end
    endcase
  end
  assign sum = add_a + add_b;

  logic             accept;
  logic             init_more;
  logic             free_bad;
  logic             head_ok;
  logic [IDX_W-1:0] n_clip;
  logic [IDX_W-1:0] rdata;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [IDX_W-1:0] ram_wdata;

  assign accept    = cmd_i.valid && (state_q == S_IDLE);
  assign init_more = cnt_q < n_q;
  assign free_bad  = (cmd_i.ret_index >= pool_q) || (free_q >= pool_q);
  assign head_ok   = head_q < MaxBlk;
  assign n_clip    = (block_count_i > MaxBlk) ? MaxBlk : block_count_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = sum;
    if (state_q == S_INIT) begin
      ram_we = init_more;
    end else if (accept && (cmd_i.mode == MODE_FREE) && !free_bad) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_i.ret_index[AW-1:0];
      ram_wdata = head_q;
    end
  end

  assign ram_re = accept && (cmd_i.mode == MODE_ALLOC) && (free_q != '0) && head_ok;

  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      n_q      <= '0;
      pool_q   <= '0;
      head_q   <= '0;
      free_q   <= '0;
      grant_q  <= '0;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            grant_q  <= '0;
            status_q <= ST_OK;
            state_q  <= S_RESP;
            case (cmd_i.mode)
              MODE_INIT: begin
                cnt_q   <= '0;
                n_q     <= n_clip;
                state_q <= S_INIT;
              end
              MODE_ALLOC: begin
                if (free_q == '0) begin
                  status_q <= ST_EMPTY;
                end else begin
                  state_q <= S_POP;
                end
              end
              MODE_FREE: begin
                if (free_bad) begin
                  status_q <= ST_BAD;
                end else begin
                  head_q <= cmd_i.ret_index;
                  free_q <= sum;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          if (init_more) begin
            cnt_q <= sum;
          end else begin
            pool_q  <= n_q;
            head_q  <= '0;
            free_q  <= n_q;
            state_q <= S_RESP;
          end
        end
        S_POP: begin
          grant_q <= head_q;
          head_q  <= head_ok ? rdata : '0;
          free_q  <= sum;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_ready_o         = (state_q == S_IDLE);
  assign res_o.valid         = (state_q == S_RESP);
  assign res_o.granted_index = grant_q;
  assign res_o.status        = status_q;
  assign res_o.free_count    = free_q;

  a_free_le_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= pool_q)
    else $error("free count above pool size");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> free_q == IDX_W'($past(free_q) - IDX_W'(1)))
    else $error("pop did not decrement free count");

  a_init_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) && !init_more |=> (head_q == '0) && (free_q == pool_q))
    else $error("init did not reset head and count");

endmodule

// ----- design/fixed_block_free_list_allocator.sv -----
// Fixed block free-list allocator.
// Hands out block indices from a pool of up to MAX_BLOCKS equal blocks kept
// as a linked free list in an on-chip link RAM (one 8-bit link per block).
// Input stream: tuser carries the command (init, allocate, free, or a no-op
// code), tdata the block index returned by a free. Every command gives one
// result transfer: granted index, status (ok, pool empty, bad free) and the
// free count after the command.
// block_count is written through cfg_we_i/cfg_wdata_i; the user writes it
// only while idle, which the block itself does not enforce. It takes effect
// at the next init command, clipped to MAX_BLOCKS. Free, no-op and allocate
// on an empty pool go straight to the result state; allocate first passes a
// pop state for one registered link RAM read; init writes one link per cycle
// for a pool of N blocks. One command is in flight at a time; the next is
// taken the cycle after its result moves into the output register.
// Reset: pool empty (free count and head zero), block_count back to 8; the
// link RAM is not cleared, init builds it.
// A stalled receiver holds the result in the output register; one further
// command may be accepted and finished, then waits until the register drains.
module fixed_block_free_list_allocator #(
  parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: block_count
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ret_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] granted_index, [15:8] free_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import fbfl_pkg::*;

  logic [IDX_W-1:0] block_count_q;
  cmd_t             cmd;
  res_t             res;
  logic             res_ready;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_grant_q;
  logic [IDX_W-1:0] out_free_q;
  status_e          out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= IDX_W'(8);
    end else if (cfg_we_i) begin
      block_count_q <= cfg_wdata_i;
    end
  end

  assign cmd.valid     = s_axis_tvalid;
  assign cmd.mode      = mode_e'(s_axis_tuser);
  assign cmd.ret_index = s_axis_tdata;

  fbfl_seq #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_count_i (block_count_q),
    .cmd_i         (cmd),
    .cmd_ready_o   (s_axis_tready),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // output register: takes a result when empty or draining this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_grant_q  <= res.granted_index;
      out_free_q   <= res.free_count;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_free_q, out_grant_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import fbfl_pkg::*;

  // cycles without any transfer before the run is declared hung; the longest
  // legal quiet stretch is the sink hold-off
  localparam int unsigned STALL_LIMIT      = 4000;
  // long sink hold-off used once to back the block up into its input
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned PHASES           = 12;
  localparam int unsigned PHASE_ITEMS      = 165;

  // one result transfer as the allocator should produce it
  typedef struct {
    logic [7:0] granted;
    status_e    status;
    logic [7:0] free_count;
  } alloc_result_t;

  // Mirrors the free list: link store, head, free count, applied pool size
  // and the block_count register. Every accepted command is run through it
  // right away, so its state always matches the block after the commands
  // accepted so far.
  class alloc_scoreboard;
    logic [7:0]    links [MAX_BLOCKS_DEF];
    logic [7:0]    head;
    int unsigned   free_blocks;
    int unsigned   pool_size;
    int unsigned   block_count;
    alloc_result_t pending_results[$];
    int unsigned   mismatches;

    function new();
      head        = '0;
      free_blocks = 0;
      pool_size   = 0;
      block_count = 8;
      mismatches  = 0;
    endfunction

    function void set_block_count(logic [7:0] value);
      block_count = value;
    endfunction

    function alloc_result_t note_command(mode_e mode, logic [7:0] idx);
      alloc_result_t res;
      int unsigned   n;
      res.granted = '0;
      res.status  = ST_OK;
      case (mode)
        MODE_INIT: begin
          n = (block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : block_count;
          for (int unsigned i = 0; i < n; i++) links[i] = 8'(i + 1);
          pool_size   = n;
          head        = '0;
          free_blocks = n;
        end
        MODE_ALLOC: begin
          if (free_blocks == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.granted = head;
            // a head past the store is only left behind by the last pop
            head = (head < MAX_BLOCKS_DEF) ? links[head] : 8'd0;
            free_blocks--;
          end
        end
        MODE_FREE: begin
          if (idx >= pool_size || free_blocks >= pool_size) begin
            res.status = ST_BAD;
          end else begin
            links[idx] = head;
            head       = idx;
            free_blocks++;
          end
        end
        default: ;
      endcase
      res.free_count = 8'(free_blocks);
      pending_results.push_back(res);
      return res;
    endfunction

    function void check_result(logic [7:0] granted, logic [1:0] status,
                               logic [7:0] free_count);
      alloc_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: granted %0d status %0d free %0d",
                 $time, granted, status, free_count);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (granted !== exp.granted) begin
        $display("%0t: granted_index expected %0d actual %0d",
                 $time, exp.granted, granted);
        mismatches++;
      end
      if (status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
        mismatches++;
      end
      if (free_count !== exp.free_count) begin
        $display("%0t: free_count expected %0d actual %0d",
                 $time, exp.free_count, free_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] ret_index
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] granted_index, [15:8] free_count
  logic [1:0]  m_axis_tuser;   // [1:0] status

  alloc_scoreboard sb;
  logic [7:0]      held_blocks[$];  // blocks granted and not yet returned
  bit              full_rate;       // both sides run without gaps
  bit              sink_hold;       // request one long sink hold-off
  int unsigned     stall_cycles;

  fixed_block_free_list_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with tvalid still high, so a back-to-back command needs no second write.
  task automatic issue_command(mode_e mode, logic [7:0] idx);
    int unsigned   gap;
    alloc_result_t exp;
    gap = full_rate ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = idx;
    do @(posedge clk_i); while (!s_axis_tready);
    exp = sb.note_command(mode, idx);
    if (mode == MODE_INIT) begin
      held_blocks.delete();
    end else if (mode == MODE_ALLOC && exp.status == ST_OK) begin
      held_blocks.push_back(exp.granted);
    end
    @(negedge clk_i);
  endtask

  // sender stops and waits out every pending result, plus a short margin
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // only called with the block drained
  task automatic set_pool_size(logic [7:0] value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_block_count(value);
  endtask

  // result side: random ready pattern, one long hold-off on request
  initial begin
    int unsigned left;
    left          = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        m_axis_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk_i);
        sink_hold = 1'b0;
        left      = 0;
      end else if (full_rate) begin
        m_axis_tready = 1'b1;
      end else if (left > 0) begin
        left--;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready = 1'b1;
        left          = $urandom_range(0, 23);
      end else begin
        m_axis_tready = 1'b0;
        left          = pick_gap();
      end
    end
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8]);
    end
  end

  // hang detection: any transfer on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned bc;
    int unsigned r;
    int unsigned pos;
    logic [7:0]  idx;

    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_NOP;
    full_rate     = 1'b0;
    sink_hold     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: pool not yet built, so allocate is empty and free is bad
    issue_command(MODE_ALLOC, 8'd0);
    issue_command(MODE_FREE, 8'd0);
    issue_command(MODE_NOP, 8'hff);
    // init with the reset block count; a free into a full pool is excess
    issue_command(MODE_INIT, 8'd0);
    issue_command(MODE_FREE, 8'd0);
    issue_command(MODE_ALLOC, 8'hff);
    drain_results();

    // three blocks: exhaust, double free, bad indices, excess free
    set_pool_size(8'd3);
    issue_command(MODE_INIT, 8'hff);
    repeat (4) issue_command(MODE_ALLOC, 8'd0);
    issue_command(MODE_FREE, 8'd1);
    issue_command(MODE_FREE, 8'd1);
    issue_command(MODE_FREE, 8'd3);
    issue_command(MODE_FREE, 8'hff);
    issue_command(MODE_FREE, 8'd0);
    issue_command(MODE_FREE, 8'd2);
    issue_command(MODE_ALLOC, 8'd0);
    drain_results();

    // largest pool: index equal to the pool size is bad, top index is fine
    set_pool_size(8'hff);
    issue_command(MODE_INIT, 8'd0);
    issue_command(MODE_ALLOC, 8'd0);
    issue_command(MODE_FREE, 8'hff);
    issue_command(MODE_FREE, 8'hfe);
    drain_results();

    // zero count builds an empty pool
    set_pool_size(8'd0);
    issue_command(MODE_INIT, 8'd0);
    issue_command(MODE_FREE, 8'd0);
    issue_command(MODE_ALLOC, 8'd0);
    drain_results();

    // random phases, each with its own pool size; the extremes come first
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: bc = 1;
        1: bc = 255;
        2: bc = 2;
        default: bc = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 254)
                                                  : $urandom_range(1, 16);
      endcase
      full_rate = (ph == 3);
      set_pool_size(8'(bc));
      issue_command(MODE_INIT, 8'($urandom_range(0, 255)));
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // back the block up into its input once
        if (ph == 5 && k == 20) sink_hold = 1'b1;
        // and let it run dry once mid-phase
        if (ph == 7 && k == 80) drain_results();
        r = $urandom_range(0, 99);
        if (r < 45 || (r < 85 && held_blocks.size() == 0)) begin
          issue_command(MODE_ALLOC, 8'($urandom_range(0, 255)));
        end else if (r < 85) begin
          pos = $urandom_range(0, held_blocks.size() - 1);
          idx = held_blocks[pos];
          held_blocks.delete(pos);
          issue_command(MODE_FREE, idx);
        end else if (r < 90) begin
          issue_command(MODE_FREE, 8'($urandom_range(0, 255)));
        end else if (r < 94) begin
          // mostly a double free of a block still on the list
          idx = (sb.pool_size == 0) ? 8'd0 : 8'($urandom_range(0, sb.pool_size - 1));
          issue_command(MODE_FREE, idx);
        end else if (r < 97 || bc > 64) begin
          issue_command(MODE_NOP, 8'($urandom_range(0, 255)));
        end else begin
          issue_command(MODE_INIT, 8'($urandom_range(0, 255)));
        end
      end
      drain_results();
    end
    full_rate = 1'b0;

    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing",
               $time, sb.mismatches, sb.pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
